// ===== rtl/stmcm_pkg.sv =====
// ----------------------------------------------------------------------------
// stmcm_pkg
// Types, event codes, register indexes and reset values used by the
// timestamp contention manager.
// ----------------------------------------------------------------------------
package stmcm_pkg;

	localparam int THREADS_DEF = 32;

	localparam int TID_W      = 5;
	localparam int FUNC_W     = 2;
	localparam int STAMP_W    = 32;
	localparam int WCOUNT_W   = 8;
	localparam int ACOUNT_W   = 4;
	localparam int MULT_W     = 16;
	localparam int BACKOFF_W  = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [FUNC_W-1:0] FUNC_START    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CHECK    = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_ROLLBACK = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ABORTS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAIT_MULT  = 2'd2;

	localparam logic [WCOUNT_W-1:0] THRESHOLD_RST  = 8'd10;
	localparam logic [ACOUNT_W-1:0] MAX_ABORTS_RST = 4'd10;
	localparam logic [MULT_W-1:0]   WAIT_MULT_RST  = 16'd8000;

	localparam logic [STAMP_W-1:0]  STAMP_TIMID = 32'hFFFF_FFFF;
	localparam logic [STAMP_W-1:0]  STAMP_LAST  = 32'hFFFF_FFFE;
	localparam logic [WCOUNT_W-1:0] WCOUNT_MAX  = 8'hFF;

	// One row of per-thread state, kept together in the table memory.
	typedef struct packed {
		logic                flag;
		logic [STAMP_W-1:0]  stamp;
		logic [WCOUNT_W-1:0] wcount;
		logic [ACOUNT_W-1:0] acount;
	} stmcm_row_t;

	localparam stmcm_row_t ROW_RESET = '{
		flag:   1'b0,
		stamp:  STAMP_TIMID,
		wcount: '0,
		acount: '0
	};

endpackage

// ===== rtl/stmcm_ram.sv =====
// ----------------------------------------------------------------------------
// stmcm_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module stmcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/stm_timestamp_contention_manager.sv =====
// ----------------------------------------------------------------------------
// stm_timestamp_contention_manager
// Per-thread contention manager with a global timestamp counter.
// ----------------------------------------------------------------------------
// An event (func, thread_id, restarted, owner_thread_id) is taken at a clock
// edge where start is high and busy is low. busy stays low: an event can be
// taken in every cycle. Each event gives exactly one result, shown on
// abort_now, aborted_by_other and backoff_limit for one cycle while done is
// high. The receiver cannot stall, so results are never held back.
// The per-thread table memory has a registered read, then one stage of
// decision logic feeds the result register. Throughput is one event per
// cycle; the last table write is forwarded to the event that follows it.
// Configuration writes go over cfg_valid/cfg_ready (always ready) with
// cfg_index and cfg_data. The user must make them only while no event is
// in flight; the block itself does not enforce this.
// Reset (arst_n low) sets all threads timid and unmarked with zero counts,
// through one valid bit per thread, clears the timestamp counter and loads
// the register defaults. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module stm_timestamp_contention_manager
	import stmcm_pkg::*;
#(
	parameter int THREADS = THREADS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [FUNC_W-1:0]     func,
	input  logic [TID_W-1:0]      thread_id,
	input  logic                  restarted,
	input  logic [TID_W-1:0]      owner_thread_id,
	output logic                  done,
	output logic                  abort_now,
	output logic                  aborted_by_other,
	output logic [BACKOFF_W-1:0]  backoff_limit,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW  = $clog2(THREADS);
	localparam int IDW = (AW > TID_W) ? AW : TID_W;
	localparam int RW  = $bits(stmcm_row_t);

	logic                accept;
	logic [WCOUNT_W-1:0] thr_q;
	logic [ACOUNT_W-1:0] max_q;
	logic [MULT_W-1:0]   mult_q;

	logic                valid_s1;
	logic [FUNC_W-1:0]   func_s1;
	logic [TID_W-1:0]    tid_s1;
	logic                restarted_s1;
	logic [TID_W-1:0]    oid_s1;

	logic [IDW-1:0]      tid_in_ext;
	logic [IDW-1:0]      oid_in_ext;
	logic [IDW-1:0]      tid_ext;
	logic [IDW-1:0]      oid_ext;
	logic [AW-1:0]       tidx;
	logic [AW-1:0]       oidx;
	logic                t_ok;
	logic                o_ok;

	logic [RW-1:0]       rd_t;
	logic [RW-1:0]       rd_o;
	stmcm_row_t          t_row;
	stmcm_row_t          o_row;

	logic [THREADS-1:0]  valid_q;
	logic                wr_en_q;
	logic [AW-1:0]       wr_addr_q;
	stmcm_row_t          wr_data_q;

	logic                we;
	logic [AW-1:0]       wa;
	stmcm_row_t          wd;
	logic [STAMP_W-1:0]  next_q;
	logic [STAMP_W-1:0]  next_d;
	logic                abort_d;
	logic                by_other_d;
	logic [BACKOFF_W-1:0] backoff_d;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Table reads start in the accepting cycle, straight from the ports.
	assign tid_in_ext = IDW'(thread_id);
	assign oid_in_ext = IDW'(owner_thread_id);

	stmcm_ram #(
		.WIDTH (RW),
		.DEPTH (THREADS)
	) u_table (
		.clk     (clk),
		.we      (we),
		.waddr   (wa),
		.wdata   (wd),
		.raddr_a (tid_in_ext[AW-1:0]),
		.rdata_a (rd_t),
		.raddr_b (oid_in_ext[AW-1:0]),
		.rdata_b (rd_o)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THRESHOLD_RST;
			max_q  <= MAX_ABORTS_RST;
			mult_q <= WAIT_MULT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_THRESHOLD:  thr_q  <= cfg_data[WCOUNT_W-1:0];
				CFG_MAX_ABORTS: max_q  <= cfg_data[ACOUNT_W-1:0];
				CFG_WAIT_MULT:  mult_q <= cfg_data[MULT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1      <= func;
			tid_s1       <= thread_id;
			restarted_s1 <= restarted;
			oid_s1       <= owner_thread_id;
		end
	end

	assign tid_ext = IDW'(tid_s1);
	assign oid_ext = IDW'(oid_s1);
	assign tidx    = tid_ext[AW-1:0];
	assign oidx    = oid_ext[AW-1:0];
	assign t_ok    = 32'(tid_s1) < THREADS;
	assign o_ok    = 32'(oid_s1) < THREADS;

	// The previous event's write reached the memory at the same edge as this
	// event's read, so it is taken from its copy instead. A row never written
	// since reset reads as the reset row.
	always_comb begin
		if (wr_en_q && wr_addr_q == tidx) begin
			t_row = wr_data_q;
		end else if (valid_q[tidx]) begin
			t_row = stmcm_row_t'(rd_t);
		end else begin
			t_row = ROW_RESET;
		end

		if (!o_ok) begin
			o_row = ROW_RESET;
		end else if (wr_en_q && wr_addr_q == oidx) begin
			o_row = wr_data_q;
		end else if (valid_q[oidx]) begin
			o_row = stmcm_row_t'(rd_o);
		end else begin
			o_row = ROW_RESET;
		end
	end

	always_comb begin
		we         = 1'b0;
		wa         = tidx;
		wd         = t_row;
		next_d     = next_q;
		abort_d    = 1'b0;
		by_other_d = 1'b0;
		backoff_d  = '0;
		if (valid_s1 && t_ok) begin
			case (func_s1)
				FUNC_START: begin
					we        = 1'b1;
					wd.flag   = 1'b0;
					wd.wcount = '0;
					if (!restarted_s1) begin
						wd.stamp  = STAMP_TIMID;
						wd.acount = '0;
					end
				end
				FUNC_WRITE: begin
					we = 1'b1;
					if (t_row.wcount != WCOUNT_MAX) begin
						wd.wcount = t_row.wcount + 1'b1;
					end
					if (t_row.stamp == STAMP_TIMID && wd.wcount == thr_q) begin
						wd.stamp = next_q;
						if (next_q < STAMP_LAST) begin
							next_d = next_q + 1'b1;
						end
					end
				end
				FUNC_CHECK: begin
					if (t_row.flag) begin
						abort_d    = 1'b1;
						by_other_d = 1'b1;
					end else if (t_row.stamp == STAMP_TIMID) begin
						abort_d = 1'b1;
					end else if (o_row.stamp < t_row.stamp) begin
						abort_d = !o_row.flag;
					end else if (o_ok) begin
						// The requester wins: mark the lock owner aborted.
						we      = 1'b1;
						wa      = oidx;
						wd      = o_row;
						wd.flag = 1'b1;
					end
				end
				FUNC_ROLLBACK: begin
					we = 1'b1;
					if (t_row.acount < max_q) begin
						wd.acount = t_row.acount + 1'b1;
					end
					backoff_d = BACKOFF_W'(wd.acount) * BACKOFF_W'(mult_q);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done     <= 1'b0;
			wr_en_q  <= 1'b0;
			valid_q  <= '0;
			next_q   <= '0;
		end else begin
			valid_s1 <= accept;
			done     <= valid_s1;
			wr_en_q  <= we;
			next_q   <= next_d;
			if (we) begin
				valid_q[wa] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q        <= wa;
		wr_data_q        <= wd;
		abort_now        <= abort_d;
		aborted_by_other <= by_other_d;
		backoff_limit    <= backoff_d;
	end

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("event in decision stage gave no result");

	a_stamp_never_timid: assert property (@(posedge clk) disable iff (!arst_n)
		next_q != STAMP_TIMID)
		else $error("timestamp counter reached the timid value");

	a_by_other_aborts: assert property (@(posedge clk) disable iff (!arst_n)
		(done && aborted_by_other) |-> abort_now)
		else $error("marked abort reported without abort");

	a_backoff_rollback: assert property (@(posedge clk) disable iff (!arst_n)
		(done && backoff_limit != '0) |-> $past(valid_s1 && func_s1 == FUNC_ROLLBACK))
		else $error("backoff bound reported for an event other than rollback");

	a_write_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> valid_q[$past(wa)])
		else $error("written table row not marked valid");

endmodule
